// File: rtl/core/gfa_pkg.sv
// Shared types and constants for the grid rectangle first-fit allocator.
`default_nettype none

package gfa_pkg;

	// Default grid size
	localparam int unsigned GRID_COLS_DEF = 8;
	localparam int unsigned GRID_ROWS_DEF = 15;

	// Width of a grid coordinate, a rectangle size and the words' fields
	localparam int unsigned DIM_W       = 4;
	localparam int unsigned SLOT_W      = 7;
	localparam int unsigned COUNT_W     = 7;
	localparam int unsigned SLOT_FULL_W = 16;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 7'h7F;

	localparam logic MODE_PLACE = 1'b0;
	localparam logic MODE_CLEAR = 1'b1;

	typedef enum logic [1:0] {
		ST_PLACED  = 2'd0,
		ST_NOFIT   = 2'd1,
		ST_CLEARED = 2'd2
	} gfa_status_t;

	typedef struct packed {
		logic             mode;
		logic [DIM_W-1:0] rect_width;
		logic [DIM_W-1:0] rect_height;
	} gfa_req_t;

	typedef struct packed {
		gfa_status_t        status;
		logic [SLOT_W-1:0]  slot_index;
		logic [COUNT_W-1:0] placed_count;
	} gfa_rsp_t;

	// Rectangle to be marked occupied in the grid
	typedef struct packed {
		logic             en;
		logic [DIM_W-1:0] row;
		logic [DIM_W-1:0] col;
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;
	} gfa_mark_t;

endpackage

`default_nettype wire

// File: rtl/core/gfa_fit_unit.sv
// Column-parallel fit check for one grid row, shared across the row scan.
`default_nettype none

module gfa_fit_unit #(
	parameter int unsigned GRID_COLS = gfa_pkg::GRID_COLS_DEF,
	parameter int unsigned GRID_ROWS = gfa_pkg::GRID_ROWS_DEF,
	localparam int unsigned COL_W = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1,
	localparam int unsigned RUN_W = $clog2(GRID_ROWS + 1)
) (
	input  logic [GRID_COLS-1:0]            row_bits,
	input  logic [GRID_COLS-1:0][RUN_W-1:0] run_in,
	input  logic [gfa_pkg::DIM_W-1:0]       w,
	input  logic [gfa_pkg::DIM_W-1:0]       h,
	output logic [GRID_COLS-1:0][RUN_W-1:0] run_out,
	output logic                            fit,
	output logic [COL_W-1:0]                fit_col
);
	import gfa_pkg::*;

	localparam int unsigned CW    = DIM_W + 2;
	localparam int unsigned CMP_W = (RUN_W > DIM_W) ? RUN_W : DIM_W;

	logic [GRID_COLS-1:0] ok;
	logic [GRID_COLS-1:0] fit_v;

	// Free-run length downward from this row, per column
	always_comb begin
		for (int j = 0; j < GRID_COLS; j++) begin
			run_out[j] = row_bits[j] ? '0 : run_in[j] + 1'b1;
			ok[j]      = CMP_W'(run_out[j]) >= CMP_W'(h);
		end
	end

	// An origin fits when every column of its window has enough free rows
	always_comb begin
		for (int c = 0; c < GRID_COLS; c++) begin
			fit_v[c] = (CW'(c) + CW'(w)) <= CW'(GRID_COLS);
			for (int j = 0; j < GRID_COLS; j++) begin
				if ((j >= c) && (CW'(j) < CW'(c) + CW'(w)) && !ok[j]) begin
					fit_v[c] = 1'b0;
				end
			end
		end
	end

	// Lowest fitting column wins
	always_comb begin
		fit_col = '0;
		for (int c = GRID_COLS - 1; c >= 0; c--) begin
			if (fit_v[c]) begin
				fit_col = COL_W'(c);
			end
		end
		fit = |fit_v;
	end

endmodule

`default_nettype wire

// File: rtl/core/gfa_grid.sv
// Occupancy grid: one flop row per grid row, row read, rectangle mark and clear.
`default_nettype none

module gfa_grid #(
	parameter int unsigned GRID_COLS = gfa_pkg::GRID_COLS_DEF,
	parameter int unsigned GRID_ROWS = gfa_pkg::GRID_ROWS_DEF,
	localparam int unsigned ROW_W = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 clr,
	input  gfa_pkg::gfa_mark_t   mark,
	input  logic [ROW_W-1:0]     rd_row,
	output logic [GRID_COLS-1:0] rd_bits
);
	import gfa_pkg::*;

	localparam int unsigned CW = DIM_W + 2;

	logic [GRID_COLS-1:0] rows_q [GRID_ROWS];
	logic [GRID_COLS-1:0] col_mask;

	assign rd_bits = rows_q[rd_row];

	always_comb begin
		for (int c = 0; c < GRID_COLS; c++) begin
			col_mask[c] = (CW'(c) >= CW'(mark.col)) && (CW'(c) < CW'(mark.col) + CW'(mark.w));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < GRID_ROWS; r++) begin
				rows_q[r] <= '0;
			end
		end else if (clr) begin
			for (int r = 0; r < GRID_ROWS; r++) begin
				rows_q[r] <= '0;
			end
		end else if (mark.en) begin
			for (int r = 0; r < GRID_ROWS; r++) begin
				if ((CW'(r) >= CW'(mark.row)) && (CW'(r) < CW'(mark.row) + CW'(mark.h))) begin
					rows_q[r] <= rows_q[r] | col_mask;
				end
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/grid_rect_first_fit_allocator_core.sv
// Top level of the grid rectangle first-fit allocator: sequencer, count and response register.
//
// Channel  Dir  Handshake            Word
// req      in   req_valid/req_stall  gfa_req_t  {mode, rect_width, rect_height}
// rsp      out  rsp_valid/rsp_stall  gfa_rsp_t  {status, slot_index, placed_count}
//
// A place request goes from acceptance through S_START, a scan of every grid row through the
// shared fit unit and S_MARK to S_DONE, where the response word is loaded.
// A place request that finds no origin skips the S_MARK state.
// A clear request, or a place request with zero width or height, goes from S_START to S_DONE.
// One request is in work at a time; req_stall is high from acceptance until the response
// word is loaded into the output register. Reset frees the whole grid and zeroes the count.
// A stalled response holds in the output register; the block then takes the next request.
`default_nettype none

module grid_rect_first_fit_allocator_core #(
	parameter int unsigned GRID_COLS = gfa_pkg::GRID_COLS_DEF,
	parameter int unsigned GRID_ROWS = gfa_pkg::GRID_ROWS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  gfa_pkg::gfa_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output gfa_pkg::gfa_rsp_t rsp
);
	import gfa_pkg::*;

	localparam int unsigned ROW_W = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
	localparam int unsigned COL_W = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
	localparam int unsigned RUN_W = $clog2(GRID_ROWS + 1);
	localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(GRID_ROWS - 1);
	localparam int unsigned CELLS = GRID_COLS * GRID_ROWS;

	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_SCAN,
		S_MARK,
		S_DONE
	} state_t;

	state_t                          state_q;
	gfa_req_t                        req_q;
	logic [ROW_W-1:0]                row_q;
	logic [GRID_COLS-1:0][RUN_W-1:0] run_q;
	logic                            found_q;
	logic [ROW_W-1:0]                found_row_q;
	logic [COL_W-1:0]                found_col_q;
	logic [COUNT_W-1:0]              count_q;
	gfa_rsp_t                        res_q;
	logic                            rsp_valid_q;
	gfa_rsp_t                        rsp_q;

	logic [GRID_COLS-1:0]            row_bits;
	logic [GRID_COLS-1:0][RUN_W-1:0] run_d;
	logic                            fit;
	logic [COL_W-1:0]                fit_col;
	logic                            grid_clr;
	gfa_mark_t                       mark;
	logic [SLOT_FULL_W-1:0]          slot_full;
	logic [COUNT_W-1:0]              count_next;
	logic                            size_zero;

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign size_zero  = (req_q.rect_width == '0) || (req_q.rect_height == '0);
	assign count_next = (count_q == COUNT_MAX) ? count_q : count_q + 1'b1;
	assign slot_full  = SLOT_FULL_W'(found_row_q) * SLOT_FULL_W'(GRID_COLS)
		+ SLOT_FULL_W'(found_col_q);

	// Clear frees every cell of the grid; mark fills the whole chosen rectangle
	assign grid_clr  = (state_q == S_START) && (req_q.mode == MODE_CLEAR);
	assign mark.en   = (state_q == S_MARK);
	assign mark.row  = DIM_W'(found_row_q);
	assign mark.col  = DIM_W'(found_col_q);
	assign mark.w    = req_q.rect_width;
	assign mark.h    = req_q.rect_height;

	gfa_grid #(
		.GRID_COLS (GRID_COLS),
		.GRID_ROWS (GRID_ROWS)
	) u_grid (
		.clk     (clk),
		.arst_n  (arst_n),
		.clr     (grid_clr),
		.mark    (mark),
		.rd_row  (row_q),
		.rd_bits (row_bits)
	);

	// Shared fit unit: one grid row per cycle, bottom row first, carrying
	// per-column free-run lengths upward
	gfa_fit_unit #(
		.GRID_COLS (GRID_COLS),
		.GRID_ROWS (GRID_ROWS)
	) u_fit (
		.row_bits (row_bits),
		.run_in   (run_q),
		.w        (req_q.rect_width),
		.h        (req_q.rect_height),
		.run_out  (run_d),
		.fit      (fit),
		.fit_col  (fit_col)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			req_q       <= '0;
			row_q       <= '0;
			run_q       <= '0;
			found_q     <= 1'b0;
			found_row_q <= '0;
			found_col_q <= '0;
			count_q     <= '0;
			res_q       <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			// Drop the response word once taken; S_DONE reloads it itself
			if (rsp_valid_q && !rsp_stall && (state_q != S_DONE)) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						req_q   <= req;
						state_q <= S_START;
					end
				end
				S_START: begin
					if (req_q.mode == MODE_CLEAR) begin
						count_q <= '0;
						res_q   <= '{status: ST_CLEARED, slot_index: '0, placed_count: '0};
						state_q <= S_DONE;
					end else if (size_zero) begin
						res_q   <= '{status: ST_NOFIT, slot_index: '0, placed_count: count_q};
						state_q <= S_DONE;
					end else begin
						run_q   <= '0;
						row_q   <= LAST_ROW;
						found_q <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					run_q <= run_d;
					// Scanning upward, the last hit is the first-fit origin
					if (fit) begin
						found_q     <= 1'b1;
						found_row_q <= row_q;
						found_col_q <= fit_col;
					end
					if (row_q == '0) begin
						if (found_q || fit) begin
							state_q <= S_MARK;
						end else begin
							res_q   <= '{status: ST_NOFIT, slot_index: '0, placed_count: count_q};
							state_q <= S_DONE;
						end
					end else begin
						row_q <= row_q - 1'b1;
					end
				end
				S_MARK: begin
					count_q <= count_next;
					res_q   <= '{status: ST_PLACED, slot_index: slot_full[SLOT_W-1:0],
						placed_count: count_next};
					state_q <= S_DONE;
				end
				S_DONE: begin
					// Hold until the output register is free
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_valid_q <= 1'b1;
						rsp_q       <= res_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// A placement never reports an origin outside the grid
	a_slot_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status == ST_PLACED) |->
			(SLOT_FULL_W'(rsp.slot_index) < SLOT_FULL_W'(CELLS) || CELLS > 128))
		else $error("placed slot index outside the grid");

	// A clear response carries zero slot and zero count
	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status == ST_CLEARED) |->
			(rsp.slot_index == '0 && rsp.placed_count == '0))
		else $error("clear response with nonzero fields");

	// Marking happens only after the scan found an origin
	a_mark_found: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MARK) |-> found_q)
		else $error("mark without a found origin");

	// The scan row stays inside the grid
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (row_q <= LAST_ROW))
		else $error("scan row outside the grid");

	// A clear zeroes the count on the next edge
	a_clear_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_START && req_q.mode == MODE_CLEAR) |=> (count_q == '0))
		else $error("count not zeroed by clear");

endmodule

`default_nettype wire
